// File: hdl/nested_timeout_stack_unit_macros.svh
// Assertion macros for the nested timeout stack unit.
// Used by the core and the top level; expects clk and arst_n in scope.
`ifndef NESTED_TIMEOUT_STACK_UNIT_MACROS_SVH
`define NESTED_TIMEOUT_STACK_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define NTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define NTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/nts_pkg.sv
// Shared types and constants for the nested timeout stack unit.
// No dependencies.
package nts_pkg;

	localparam int CNT_W           = 16;
	localparam int NEST_W          = 8;
	localparam int MARGIN_W        = 4;
	localparam int OP_W            = 2;
	localparam int STACK_DEPTH_DEF = 5;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd3;
	localparam logic [NEST_W-1:0]   NEST_MAX     = 8'hFF;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

	// write request into the leftover stack
	typedef struct packed {
		logic             wr_en;
		logic [CNT_W-1:0] wr_data;
	} stk_wr_t;

endpackage

// File: hdl/nested_timeout_stack_unit.sv
// A command passes through the input stage, then the result stage. Throughput: one item
// per cycle while results are taken; the timer core's single-pass update sets the rate.
// A result stalled on res_ready holds timer state; commands keep flowing into
// the input stage while it is empty. Reset (arst_n low, async) stops and clears
// the counter, depth and match flag, and loads margin_q with 3.
// Depends on nts_pkg, nts_core and nested_timeout_stack_unit_macros.svh.
`include "nested_timeout_stack_unit_macros.svh"

module nested_timeout_stack_unit #(
	parameter int STACK_DEPTH = nts_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [nts_pkg::MARGIN_W-1:0] cfg_wr_data,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  logic [nts_pkg::OP_W-1:0]     operation,
	input  logic [nts_pkg::CNT_W-1:0]    duration,
	input  logic                         cond,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         keep_waiting,
	output logic                         timed_out,
	output logic [nts_pkg::CNT_W-1:0]    remaining,
	output logic [nts_pkg::NEST_W-1:0]   depth
);

	logic [nts_pkg::MARGIN_W-1:0] margin_q;
	logic                         valid_s1;
	logic [nts_pkg::OP_W-1:0]     op_s1;
	logic [nts_pkg::CNT_W-1:0]    dur_s1;
	logic                         cond_s1;
	logic                         res_valid_q, keep_q, keep_d;
	logic                         advance, cmd_accept;

	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready  = !valid_s1 || advance;
	assign cmd_accept = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= nts_pkg::MARGIN_RESET;
		end else if (cfg_wr_en) begin
			margin_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			op_s1   <= operation;
			dur_s1  <= duration;
			cond_s1 <= cond;
		end
	end

	nts_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.op       (op_s1),
		.dur      (dur_s1),
		.cond     (cond_s1),
		.margin   (margin_q),
		.keep     (keep_d),
		.timed_out(timed_out),
		.remaining(remaining),
		.depth    (depth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			keep_q <= keep_d;
		end
	end

	assign res_valid    = res_valid_q;
	assign keep_waiting = keep_q;

	`NTS_ASSERT_NEXT(a_adv_gives_result, advance, res_valid_q,
		"advanced item produced no result")
	`NTS_ASSERT_NEXT(a_accept_fills_s1, cmd_accept, valid_s1,
		"accepted item missing from input stage")
	`NTS_ASSERT_NOW(a_no_overwrite, valid_s1 && res_valid_q && !res_ready, !cmd_ready,
		"input stage open while blocked")

endmodule

// File: hdl/nts_stack.sv
// Leftover stack: saved outer-timeout leftovers, one write and one read port.
// Depends on nts_pkg. Entries hold garbage until written.
module nts_stack #(
	parameter int STACK_DEPTH = nts_pkg::STACK_DEPTH_DEF
) (
	input  logic                                         clk,
	input  nts_pkg::stk_wr_t                             wr,
	input  logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] wr_idx,
	input  logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] rd_idx,
	output logic [nts_pkg::CNT_W-1:0]                    rd_data
);

	logic [nts_pkg::CNT_W-1:0] mem_q [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem_q[wr_idx] <= wr.wr_data;
		end
	end

	assign rd_data = mem_q[rd_idx];

endmodule

// File: hdl/nts_core.sv
// Timer core: counter, compare, match flag, nesting count and next-state logic.
// Depends on nts_pkg, nts_stack and nested_timeout_stack_unit_macros.svh.
`include "nested_timeout_stack_unit_macros.svh"

module nts_core #(
	parameter int STACK_DEPTH = nts_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [nts_pkg::OP_W-1:0]     op,
	input  logic [nts_pkg::CNT_W-1:0]    dur,
	input  logic                         cond,
	input  logic [nts_pkg::MARGIN_W-1:0] margin,
	output logic                         keep,
	output logic                         timed_out,
	output logic [nts_pkg::CNT_W-1:0]    remaining,
	output logic [nts_pkg::NEST_W-1:0]   depth
);

	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [nts_pkg::NEST_W-1:0] SD_N = nts_pkg::NEST_W'(STACK_DEPTH);

	logic [nts_pkg::CNT_W-1:0]  cnt_q, cnt_d, cmp_q, cmp_d;
	logic                       running_q, running_d, flag_q, flag_d;
	logic [nts_pkg::NEST_W-1:0] nest_q, nest_d;

	logic [nts_pkg::CNT_W-1:0]  left, cnt_inc, base_hi, push_cmp, pop_cmp, rd_data;
	logic [nts_pkg::NEST_W-1:0] nest_dec, nest_m1, nest_m2;
	logic                       cmp_ahead;
	nts_pkg::stk_wr_t           wr;

	assign cmp_ahead = cmp_q > cnt_q;
	assign left      = cmp_ahead ? (cmp_q - cnt_q) : '0;
	assign cnt_inc   = cnt_q + 1'b1;
	// re-arm adds to whatever is left: cnt + left is cmp when ahead, else cnt
	assign base_hi   = cmp_ahead ? cmp_q : cnt_q;
	assign push_cmp  = dur + nts_pkg::CNT_W'(margin) + cnt_q;
	assign pop_cmp   = base_hi + rd_data + nts_pkg::CNT_W'(margin);
	assign nest_dec  = (nest_q != '0) ? (nest_q - 1'b1) : '0;
	assign nest_m1   = nest_q - 1'b1;
	assign nest_m2   = nest_q - 2'd2;

	nts_stack #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr     (wr),
		.wr_idx (nest_m1[IDX_W-1:0]),
		.rd_idx (nest_m2[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_comb begin
		cnt_d      = cnt_q;
		cmp_d      = cmp_q;
		running_d  = running_q;
		flag_d     = flag_q;
		nest_d     = nest_q;
		keep       = 1'b0;
		wr.wr_en   = 1'b0;
		wr.wr_data = '0;
		unique case (op)
			nts_pkg::OP_TICK: begin
				if (running_q) begin
					cnt_d = cnt_inc;
					if (cnt_inc == cmp_q) begin
						flag_d = 1'b1;
					end
				end
			end
			nts_pkg::OP_PUSH: begin
				if (dur != '0 && !flag_q) begin
					if (nest_q <= SD_N) begin
						if (nest_q != '0) begin
							wr.wr_en = 1'b1;
							if (left > dur) begin
								wr.wr_data = left - dur;
								cmp_d      = push_cmp;
								flag_d     = 1'b0;
								running_d  = 1'b1;
							end
						end else begin
							cmp_d     = push_cmp;
							flag_d    = 1'b0;
							running_d = 1'b1;
						end
					end
					if (nest_q != nts_pkg::NEST_MAX) begin
						nest_d = nest_q + 1'b1;
					end
				end
			end
			nts_pkg::OP_CHECK: begin
				if (flag_q || !cond) begin
					nest_d = nest_dec;
					if (nest_dec == '0) begin
						running_d = 1'b0;
						cmp_d     = '0;
						cnt_d     = '0;
						flag_d    = 1'b0;
					end else if (nest_dec <= SD_N && rd_data != '0) begin
						cmp_d     = pop_cmp;
						flag_d    = 1'b0;
						running_d = 1'b1;
					end
				end else begin
					keep = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (!en) begin
			wr.wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			cmp_q     <= '0;
			running_q <= 1'b0;
			flag_q    <= 1'b0;
			nest_q    <= '0;
		end else if (en) begin
			cnt_q     <= cnt_d;
			cmp_q     <= cmp_d;
			running_q <= running_d;
			flag_q    <= flag_d;
			nest_q    <= nest_d;
		end
	end

	// results read straight from state; state only moves when a new result loads
	assign timed_out = flag_q;
	assign remaining = left;
	assign depth     = nest_q;

	`NTS_ASSERT_NOW(a_idle_when_empty, nest_q == '0,
		!running_q && cnt_q == '0 && cmp_q == '0, "timer not cleared at depth zero")
	`NTS_ASSERT_NOW(a_flag_needs_run, !running_q, !flag_q,
		"match flag set while counter stopped")
	`NTS_ASSERT_NEXT(a_hold_when_idle, !en, $stable(nest_q) && $stable(cnt_q),
		"state moved without an item")

endmodule

// File: sim/nts_checker.sv
// Result checker for the nested timeout stack unit: tracks the timer state from
// accepted commands and compares every accepted result in order.
// Depends on nts_pkg.
module nts_checker #(
	parameter int STACK_DEPTH = nts_pkg::STACK_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [nts_pkg::MARGIN_W-1:0] cfg_wr_data,
	input  logic                         cmd_valid,
	input  logic                         cmd_ready,
	input  logic [nts_pkg::OP_W-1:0]     operation,
	input  logic [nts_pkg::CNT_W-1:0]    duration,
	input  logic                         cond,
	input  logic                         res_valid,
	input  logic                         res_ready,
	input  logic                         keep_waiting,
	input  logic                         timed_out,
	input  logic [nts_pkg::CNT_W-1:0]    remaining,
	input  logic [nts_pkg::NEST_W-1:0]   depth,
	output int                           fail_count,
	output int                           outstanding,
	output int                           checked,
	output int                           deepest,
	output int                           pops
);

	typedef struct packed {
		logic                       keep;
		logic                       flag;
		logic [nts_pkg::CNT_W-1:0]  left;
		logic [nts_pkg::NEST_W-1:0] nest;
	} timeout_result_t;

	logic [nts_pkg::CNT_W-1:0]    tick_cnt;
	logic [nts_pkg::CNT_W-1:0]    cmp_val;
	logic                         run_q;
	logic                         match_q;
	logic [nts_pkg::NEST_W-1:0]   nest_q;
	logic [nts_pkg::MARGIN_W-1:0] margin_q;
	logic [nts_pkg::CNT_W-1:0]    leftover_stack [STACK_DEPTH];

	timeout_result_t expected_q [$];

	function automatic logic [nts_pkg::CNT_W-1:0] time_to_go();
		return (cmp_val > tick_cnt) ? cmp_val - tick_cnt : '0;
	endfunction

	function automatic void rearm(input logic [nts_pkg::CNT_W-1:0] t);
		cmp_val = t + margin_q + tick_cnt;
		match_q = 1'b0;
		run_q   = 1'b1;
	endfunction

	function automatic timeout_result_t advance_timeouts(input logic [nts_pkg::OP_W-1:0] op,
			input logic [nts_pkg::CNT_W-1:0] dur, input logic c);
		timeout_result_t           r;
		logic [nts_pkg::CNT_W-1:0] left;
		logic [nts_pkg::CNT_W-1:0] saved;
		r = '0;
		case (op)
			nts_pkg::OP_TICK: begin
				if (run_q) begin
					tick_cnt = tick_cnt + 1'b1;
					if (tick_cnt == cmp_val)
						match_q = 1'b1;
				end
			end
			nts_pkg::OP_PUSH: begin
				if (dur != '0 && !match_q) begin
					// beyond the stack the push only counts depth
					if (nest_q <= STACK_DEPTH) begin
						if (nest_q != '0) begin
							left = time_to_go();
							if (left > dur) begin
								leftover_stack[nest_q - 1] = left - dur;
								rearm(dur);
							end else begin
								leftover_stack[nest_q - 1] = '0;
							end
						end else begin
							rearm(dur);
						end
					end
					if (nest_q != nts_pkg::NEST_MAX)
						nest_q = nest_q + 1'b1;
				end
			end
			nts_pkg::OP_CHECK: begin
				if (match_q || !c) begin
					pops++;
					if (nest_q != '0)
						nest_q = nest_q - 1'b1;
					if (nest_q == '0) begin
						run_q    = 1'b0;
						cmp_val  = '0;
						tick_cnt = '0;
						match_q  = 1'b0;
					end else if (nest_q <= STACK_DEPTH) begin
						saved = leftover_stack[nest_q - 1];
						if (saved != '0)
							rearm(time_to_go() + saved);
					end
				end else begin
					r.keep = 1'b1;
				end
			end
			default: ;
		endcase
		r.flag = match_q;
		r.left = time_to_go();
		r.nest = nest_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timeout_result_t want;
		if (!arst_n) begin
			tick_cnt = '0;
			cmp_val  = '0;
			run_q    = 1'b0;
			match_q  = 1'b0;
			nest_q   = '0;
			margin_q = nts_pkg::MARGIN_RESET;
			for (int i = 0; i < STACK_DEPTH; i++)
				leftover_stack[i] = '0;
			expected_q.delete();
			fail_count  = 0;
			outstanding = 0;
			checked     = 0;
			deepest     = 0;
			pops        = 0;
		end else begin
			// results leave before the command of this edge enters
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with no item waiting");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (keep_waiting !== want.keep) begin
						$error("keep_waiting: expected %0d, got %0d", want.keep, keep_waiting);
						fail_count++;
					end
					if (timed_out !== want.flag) begin
						$error("timed_out: expected %0d, got %0d", want.flag, timed_out);
						fail_count++;
					end
					if (remaining !== want.left) begin
						$error("remaining: expected %0d, got %0d", want.left, remaining);
						fail_count++;
					end
					if (depth !== want.nest) begin
						$error("depth: expected %0d, got %0d", want.nest, depth);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				margin_q = cfg_wr_data;
			if (cmd_valid && cmd_ready) begin
				expected_q.push_back(advance_timeouts(operation, duration, cond));
				if (nest_q > deepest)
					deepest = nest_q;
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// File: sim/tb_nested_timeout_stack_unit.sv
// Testbench top for the nested timeout stack unit: drives commands, the margin
// register and result backpressure; nts_checker does the prediction and compare.
// Depends on nts_pkg, nts_checker and the unit itself.
module tb_nested_timeout_stack_unit;

	localparam logic [nts_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	localparam int WATCHDOG_LIMIT    = 5000;
	localparam int SETTLE_CYCLES     = 10;
	localparam int LONG_STALL_CYCLES = 240;
	localparam int DIRECTED_ITEMS    = 24;
	localparam int RANDOM_ITEMS      = 1850;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wr_en   = 1'b0;
	logic [nts_pkg::MARGIN_W-1:0] cfg_wr_data = '0;
	logic                         cmd_valid   = 1'b0;
	logic [nts_pkg::OP_W-1:0]     operation   = nts_pkg::OP_TICK;
	logic [nts_pkg::CNT_W-1:0]    duration    = '0;
	logic                         cond        = 1'b0;
	logic                         res_ready   = 1'b0;

	logic                       cmd_ready;
	logic                       res_valid;
	logic                       keep_waiting;
	logic                       timed_out;
	logic [nts_pkg::CNT_W-1:0]  remaining;
	logic [nts_pkg::NEST_W-1:0] depth;

	int fail_count;
	int outstanding;
	int checked;
	int deepest;
	int pops;

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int items_sent     = 0;
	int depth_bound    = 0;
	int stall_requests = 0;
	int stall_served   = 0;
	int stall_left     = 0;
	int quiet_cycles   = 0;
	int last_margin    = 0;

	always #5 clk = ~clk;

	nested_timeout_stack_unit #(
		.STACK_DEPTH(nts_pkg::STACK_DEPTH_DEF)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.operation   (operation),
		.duration    (duration),
		.cond        (cond),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.keep_waiting(keep_waiting),
		.timed_out   (timed_out),
		.remaining   (remaining),
		.depth       (depth)
	);

	nts_checker #(
		.STACK_DEPTH(nts_pkg::STACK_DEPTH_DEF)
	) result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.operation   (operation),
		.duration    (duration),
		.cond        (cond),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.keep_waiting(keep_waiting),
		.timed_out   (timed_out),
		.remaining   (remaining),
		.depth       (depth),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked),
		.deepest     (deepest),
		.pops        (pops)
	);

	// result backpressure; a long hold-off starts whenever the stimulus asks for one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready    <= 1'b0;
			stall_left   <= 0;
			stall_served <= 0;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_requests;
			stall_left   <= LONG_STALL_CYCLES;
			res_ready    <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_ready  <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [nts_pkg::CNT_W-1:0] rand_word();
		return nts_pkg::CNT_W'($urandom);
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	task automatic send_item(input logic [nts_pkg::OP_W-1:0] op,
			input logic [nts_pkg::CNT_W-1:0] dur, input logic c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		operation <= op;
		duration  <= dur;
		cond      <= c;
		do @(posedge clk); while (!cmd_ready);
		items_sent++;
		// upper bound on nesting so the stimulus knows how many pops close everything
		if (op == nts_pkg::OP_PUSH && dur != '0 && depth_bound < nts_pkg::NEST_MAX)
			depth_bound++;
		if (op == nts_pkg::OP_CHECK && !c && depth_bound > 0)
			depth_bound--;
	endtask

	function automatic logic [nts_pkg::CNT_W-1:0] pick_duration();
		case ($urandom_range(9))
			0:       return '1;
			1:       return rand_word();
			2, 3:    return nts_pkg::CNT_W'($urandom_range(60, 1));
			default: return nts_pkg::CNT_W'($urandom_range(25, 1));
		endcase
	endfunction

	task automatic tick_burst(input int n);
		repeat (n) send_item(nts_pkg::OP_TICK, rand_word(), rand_bit());
	endtask

	task automatic close_out();
		while (depth_bound > 0) send_item(nts_pkg::OP_CHECK, rand_word(), 1'b0);
	endtask

	// wait until every result is back and the pipeline has settled
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(input logic [nts_pkg::MARGIN_W-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		last_margin = int'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// pushes with ticks between, then checks until the timeouts unwind
	task automatic nested_run();
		int levels;
		levels = $urandom_range(8, 1);
		repeat (levels) begin
			send_item(nts_pkg::OP_PUSH, pick_duration(), rand_bit());
			tick_burst($urandom_range(4));
		end
		repeat (2 * levels) begin
			tick_burst($urandom_range(15));
			if ($urandom_range(5) == 0)
				send_item(nts_pkg::OP_PUSH, pick_duration(), rand_bit());
			send_item(nts_pkg::OP_CHECK, rand_word(), $urandom_range(3) != 0);
		end
		close_out();
	endtask

	task automatic noise_run();
		repeat ($urandom_range(8, 2))
			send_item(nts_pkg::OP_W'($urandom_range(3)), rand_word(), rand_bit());
	endtask

	task automatic run_mixed(input int upto);
		while (items_sent < upto) begin
			if ($urandom_range(9) < 2)
				noise_run();
			else
				nested_run();
		end
		close_out();
	endtask

	// push far past the stack to the depth ceiling, then unwind to zero
	task automatic deep_run();
		close_out();
		repeat (nts_pkg::NEST_MAX + 3) begin
			send_item(nts_pkg::OP_PUSH, nts_pkg::CNT_W'($urandom_range(16'hFFFF, 1)),
				rand_bit());
			if ($urandom_range(7) == 0)
				send_item(nts_pkg::OP_CHECK, rand_word(), 1'b1);
		end
		close_out();
	endtask

	// arm past 65535 so the compare value wraps, then tick and pop the level
	task automatic wrap_run();
		close_out();
		send_item(nts_pkg::OP_PUSH, '1, 1'b0);
		tick_burst(20);
		send_item(nts_pkg::OP_CHECK, rand_word(), 1'b0);
		depth_bound = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct <= 73;

		// directed part, margin still at its reset value
		send_item(nts_pkg::OP_TICK, '0, 1'b0);           // counter stopped
		send_item(nts_pkg::OP_CHECK, '1, 1'b1);          // nothing to pop, keep waiting
		send_item(nts_pkg::OP_CHECK, '0, 1'b0);          // pop at depth zero stays zero
		send_item(nts_pkg::OP_PUSH, '0, 1'b1);           // zero duration refused
		send_item(OP_SPARE, '1, 1'b1);                   // unused operation
		send_item(nts_pkg::OP_PUSH, 16'd5, 1'b0);        // arm outermost
		send_item(nts_pkg::OP_PUSH, 16'd2, 1'b1);        // shorter inner, leftover saved
		send_item(nts_pkg::OP_PUSH, 16'd10, 1'b0);       // longer inner, outer kept
		repeat (5) send_item(nts_pkg::OP_TICK, 16'hA5A5, 1'b1);
		send_item(nts_pkg::OP_PUSH, 16'd7, 1'b0);        // refused while matched
		send_item(nts_pkg::OP_CHECK, '0, 1'b1);          // pop on match, nothing saved
		send_item(nts_pkg::OP_CHECK, '0, 1'b1);          // pop restores the saved leftover
		send_item(nts_pkg::OP_CHECK, '0, 1'b1);          // keep waiting
		send_item(nts_pkg::OP_PUSH, '1, 1'b0);
		send_item(nts_pkg::OP_CHECK, '0, 1'b0);
		send_item(nts_pkg::OP_CHECK, '0, 1'b0);          // back to zero, counter cleared
		send_item(nts_pkg::OP_PUSH, '1, 1'b1);           // compare value wraps
		send_item(nts_pkg::OP_TICK, 16'h5A5A, 1'b0);
		send_item(nts_pkg::OP_TICK, 16'h0F0F, 1'b1);
		send_item(nts_pkg::OP_CHECK, '0, 1'b0);

		write_margin('1);
		run_mixed(DIRECTED_ITEMS + 550);

		send_idle_pct = 73;
		recv_idle_pct <= 26;
		write_margin('0);
		run_mixed(DIRECTED_ITEMS + 1100);

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		write_margin(nts_pkg::MARGIN_W'($urandom_range(14, 1)));
		stall_requests <= stall_requests + 1;
		deep_run();
		run_mixed(DIRECTED_ITEMS + RANDOM_ITEMS);
		wrap_run();

		drain();
		$display("Covered %0d items and %0d checked results: %0d pops, nesting up to %0d,",
			items_sent, checked, pops, deepest);
		$display("margin settings 3, 15, 0 and %0d, a long result stall and a wrapped compare.",
			last_margin);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/nts_pkg.sv
hdl/nts_stack.sv
hdl/nts_core.sv
hdl/nested_timeout_stack_unit.sv
sim/nts_checker.sv
sim/tb_nested_timeout_stack_unit.sv
